>>> hdl/ipd_pkg.sv
package ipd_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned ERR_W    = 13;
    localparam int unsigned GAIN_W   = 32;
    localparam int unsigned EFFORT_W = 31;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned DUTY_W   = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Shared multiplier: 32-bit signed by 17-bit signed
    localparam int unsigned MUL_B_W  = 17;
    localparam int unsigned PROD_W   = GAIN_W + MUL_B_W;
    localparam int unsigned Q_SHIFT  = 30;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CUR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PREV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd5;

    // Register reset values
    localparam logic [SAMPLE_W-1:0]        RST_REFERENCE = 12'd2284;
    localparam logic signed [GAIN_W-1:0]   RST_GAIN_CUR  = 32'sd34611;
    localparam logic signed [GAIN_W-1:0]   RST_GAIN_PREV = -32'sd32665;
    localparam logic [EFFORT_W-1:0]        RST_UPPER     = 31'd1020054733;
    localparam logic [EFFORT_W-1:0]        RST_LOWER     = 31'd0;
    localparam logic [PERIOD_W-1:0]        RST_PERIOD    = 16'd1250;

    // Multiplier operand selection
    localparam logic [1:0] MUL_CUR  = 2'd0;
    localparam logic [1:0] MUL_PREV = 2'd1;
    localparam logic [1:0] MUL_PWM  = 2'd2;

    typedef struct packed {
        logic       capture;   // take sample, form error
        logic       mul_en;    // register a product
        logic [1:0] mul_sel;
        logic       acc_load;  // last effort plus present-error product
        logic       clamp;     // add, clamp, update loop state
        logic       load_out;  // fill output register
    } t_cmd;

endpackage

>>> hdl/incremental_pi_pwm_duty.sv
// Channel   Direction  Handshake                 Payload
// in        in         i_in_valid / o_in_stall   i_sample
// out       out        o_out_valid / i_out_stall o_duty_count, o_effort, o_hit_upper,
//                                                o_hit_lower
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each sample passes from acceptance to the output register through three products
// (present error, previous error, effort times period) in one shared 32x17
// signed multiplier, plus a clamp step and an output load.
// The next sample is taken the cycle after the load.
// The input stalls while an update is in flight; a waiting result holds in the
// output register, and a stall there holds the update at its last step.
// Synchronous active-low reset restores the register defaults and zeroes the loop state.
module incremental_pi_pwm_duty
    import ipd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DUTY_W-1:0]     o_duty_count,
    output logic [EFFORT_W-1:0]   o_effort,
    output logic                  o_hit_upper,
    output logic                  o_hit_lower,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    ipd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ipd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (i_sample),
        .o_duty_count (o_duty_count),
        .o_effort     (o_effort),
        .o_hit_upper  (o_hit_upper),
        .o_hit_lower  (o_hit_lower)
    );

endmodule

>>> hdl/ipd_ctrl.sv
module ipd_ctrl
    import ipd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL0  = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_CLAMP = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CUR;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_PREV;
                o_cmd.acc_load = 1'b1;
                n_state        = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PWM;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the transaction
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.load_out)
        else $error("output register overwritten while stalled");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MUL0))
        else $error("accepted transaction did not start the update");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.acc_load, o_cmd.clamp, o_cmd.load_out}))
        else $error("more than one datapath step commanded");

    a_load_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

>>> hdl/ipd_dp.sv
module ipd_dp
    import ipd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic [DUTY_W-1:0]     o_duty_count,
    output logic [EFFORT_W-1:0]   o_effort,
    output logic                  o_hit_upper,
    output logic                  o_hit_lower
);

    // Configuration registers
    logic [SAMPLE_W-1:0]      r_reference;
    logic signed [GAIN_W-1:0] r_gain_cur;
    logic signed [GAIN_W-1:0] r_gain_prev;
    logic [EFFORT_W-1:0]      r_upper;
    logic [EFFORT_W-1:0]      r_lower;
    logic [PERIOD_W-1:0]      r_period;

    // Loop state
    logic [EFFORT_W-1:0]      r_last_effort, n_last_effort;
    logic signed [ERR_W-1:0]  r_last_error;

    // Working registers
    logic signed [ERR_W-1:0]  r_err, n_err;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic                     r_hit_upper, r_hit_lower;
    logic                     n_hit_upper, n_hit_lower;

    // Output registers
    logic [DUTY_W-1:0]        r_out_duty, n_out_duty;
    logic [EFFORT_W-1:0]      r_out_effort;
    logic                     r_out_upper, r_out_lower;

    logic signed [GAIN_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  sum, upper_ext, lower_ext, after_upper, clamped;

    assign n_err = $signed({1'b0, r_reference}) - $signed({1'b0, i_sample});

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_CUR: begin
                mul_a = r_gain_cur;
                mul_b = MUL_B_W'(r_err);
            end
            MUL_PREV: begin
                mul_a = r_gain_prev;
                mul_b = MUL_B_W'(r_last_error);
            end
            MUL_PWM: begin
                mul_a = $signed({1'b0, r_last_effort});
                mul_b = $signed({1'b0, r_period});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // Upper clamp first, then lower; lower wins when the limits cross
    assign sum         = r_acc + r_prod;
    assign upper_ext   = $signed({{(PROD_W-EFFORT_W){1'b0}}, r_upper});
    assign lower_ext   = $signed({{(PROD_W-EFFORT_W){1'b0}}, r_lower});
    assign n_hit_upper = (sum > upper_ext);
    assign after_upper = n_hit_upper ? upper_ext : sum;
    assign n_hit_lower = (after_upper < lower_ext);
    assign clamped     = n_hit_lower ? lower_ext : after_upper;
    assign n_last_effort = clamped[EFFORT_W-1:0];

    // Saturate the compare count at 16 bits
    assign n_out_duty = (r_prod[PROD_W-1:Q_SHIFT+DUTY_W] != '0) ? {DUTY_W{1'b1}}
                                                               : r_prod[Q_SHIFT+DUTY_W-1:Q_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference   <= RST_REFERENCE;
            r_gain_cur    <= RST_GAIN_CUR;
            r_gain_prev   <= RST_GAIN_PREV;
            r_upper       <= RST_UPPER;
            r_lower       <= RST_LOWER;
            r_period      <= RST_PERIOD;
            r_last_effort <= '0;
            r_last_error  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REFERENCE: r_reference <= i_cfg_data[SAMPLE_W-1:0];
                    REG_GAIN_CUR:  r_gain_cur  <= $signed(i_cfg_data);
                    REG_GAIN_PREV: r_gain_prev <= $signed(i_cfg_data);
                    REG_UPPER:     r_upper     <= i_cfg_data[EFFORT_W-1:0];
                    REG_LOWER:     r_lower     <= i_cfg_data[EFFORT_W-1:0];
                    REG_PERIOD:    r_period    <= i_cfg_data[PERIOD_W-1:0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
            if (i_cmd.clamp) begin
                r_last_effort <= n_last_effort;
                r_last_error  <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_err <= n_err;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.acc_load) begin
            r_acc <= $signed({{(PROD_W-EFFORT_W){1'b0}}, r_last_effort}) + r_prod;
        end
        if (i_cmd.clamp) begin
            r_hit_upper <= n_hit_upper;
            r_hit_lower <= n_hit_lower;
        end
        if (i_cmd.load_out) begin
            r_out_duty   <= n_out_duty;
            r_out_effort <= r_last_effort;
            r_out_upper  <= r_hit_upper;
            r_out_lower  <= r_hit_lower;
        end
    end

    assign o_duty_count = r_out_duty;
    assign o_effort     = r_out_effort;
    assign o_hit_upper  = r_out_upper;
    assign o_hit_lower  = r_out_lower;

    a_effort_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.clamp && !n_hit_lower) |-> (n_last_effort <= r_upper))
        else $error("clamped effort above upper limit");

    a_error_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clamp |=> (r_last_error == $past(r_err)))
        else $error("previous error not updated");

    a_lower_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.clamp && n_hit_lower) |=> (r_last_effort == r_lower))
        else $error("lower clamp not applied");

endmodule
